### hdl/rtp_header_deframer_core_defines.svh
// Assertion macros shared by the RTP header deframer RTL.
`ifndef RTP_HEADER_DEFRAMER_CORE_DEFINES_SVH
`define RTP_HEADER_DEFRAMER_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define RHD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define RHD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/rhd_pkg.sv
// Package with the types and constants of the RTP header deframer.
package rhd_pkg;

	localparam int unsigned IDX_W = 7;
	localparam logic [IDX_W-1:0] HDR_BASE = 7'd12;
	localparam logic [IDX_W-1:0] HDR_MAX = 7'd72;
	localparam logic [IDX_W-1:0] IDX_SEQ_HI = 7'd2;
	localparam logic [IDX_W-1:0] IDX_SEQ_LO = 7'd3;
	localparam logic [IDX_W-1:0] IDX_TS_LAST = 7'd7;

	typedef enum logic [1:0] {
		STATUS_PAYLOAD  = 2'd0,
		STATUS_HDR_ONLY = 2'd1,
		STATUS_SHORT    = 2'd2
	} status_t;

endpackage

### hdl/rtp_header_deframer_core.sv
// RTP header deframer: header capture, sequence check and payload byte output.
//
//  channel | handshake                  | payload
//  --------+----------------------------+-------------------------------------------
//  item    | item_valid / item_ready    | data_byte, last_byte
//  result  | result_valid / result_ready| payload_byte, payload_last, status, header
//
// One byte is taken per cycle; its result, if any, appears in the result register
// on the next cycle. The single result register sets the rate: a new byte is taken
// whenever that register is empty or is being read in the same cycle.
// A stalled result holds the item side only while the result is not taken.
// Reset clears the header state, the byte position and the result valid flag.
module rtp_header_deframer_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_ready,
	input  logic [7:0]            data_byte,
	input  logic                  last_byte,
	output logic                  result_valid,
	input  logic                  result_ready,
	output logic [7:0]            payload_byte,
	output logic                  payload_last,
	output rhd_pkg::status_t      status,
	output logic                  seq_error,
	output logic                  marker,
	output logic [6:0]            payload_type,
	output logic [15:0]           sequence_number,
	output logic [31:0]           timestamp,
	output logic [3:0]            csrc_count,
	output logic [1:0]            version,
	output logic                  padding_flag,
	output logic                  extension_flag
);
	import rhd_pkg::*;
	`include "rtp_header_deframer_core_defines.svh"

	logic [IDX_W-1:0] byte_index_q, byte_index_d;
	logic [7:0]       hdr_first_q, hdr_first_d;
	logic [7:0]       hdr_second_q, hdr_second_d;
	logic [15:0]      cur_seq_q, cur_seq_d;
	logic [31:0]      cur_ts_q, cur_ts_d;
	logic [15:0]      prev_seq_q, prev_seq_d;
	logic             seen_first_q, seen_first_d;
	logic             seq_err_q, seq_err_d;

	logic [IDX_W-1:0] hsize;
	logic [IDX_W:0]   idx_inc;
	logic             emit;
	status_t          status_d;
	logic [7:0]       pbyte_d;
	logic             accept;

	logic             result_valid_q;
	logic [7:0]       payload_byte_q;
	logic             payload_last_q;
	status_t          status_q;
	logic             seq_error_q;
	logic [7:0]       out_first_q;
	logic [7:0]       out_second_q;
	logic [15:0]      out_seq_q;
	logic [31:0]      out_ts_q;

	assign item_ready = !result_valid_q || result_ready;
	assign accept = item_valid && item_ready;

	always_comb begin
		hdr_first_d  = hdr_first_q;
		hdr_second_d = hdr_second_q;
		cur_seq_d    = cur_seq_q;
		cur_ts_d     = cur_ts_q;
		prev_seq_d   = prev_seq_q;
		seen_first_d = seen_first_q;
		seq_err_d    = seq_err_q;
		if (byte_index_q == '0) begin
			hdr_first_d  = data_byte;
			hdr_second_d = '0;
			cur_seq_d    = '0;
			cur_ts_d     = '0;
			seq_err_d    = 1'b0;
		end else if (byte_index_q == IDX_SEQ_HI - 7'd1) begin
			hdr_second_d = data_byte;
		end else if (byte_index_q == IDX_SEQ_HI) begin
			cur_seq_d = {data_byte, 8'h00};
		end else if (byte_index_q == IDX_SEQ_LO) begin
			cur_seq_d    = {cur_seq_q[15:8], data_byte};
			seq_err_d    = seen_first_q && (cur_seq_d != 16'(prev_seq_q + 16'd1));
			prev_seq_d   = cur_seq_d;
			seen_first_d = 1'b1;
		end else if (byte_index_q <= IDX_TS_LAST) begin
			cur_ts_d = {cur_ts_q[23:0], data_byte};
		end

		hsize   = HDR_BASE + {1'b0, hdr_first_d[3:0], 2'b00};
		idx_inc = {1'b0, byte_index_q} + 8'd1;

		if (last_byte) begin
			byte_index_d = '0;
		end else if (byte_index_q < hsize) begin
			byte_index_d = idx_inc[IDX_W-1:0];
		end else begin
			byte_index_d = byte_index_q;
		end

		emit = last_byte || (byte_index_q >= hsize);

		if (!last_byte) begin
			status_d = STATUS_PAYLOAD;
		end else if (idx_inc < {1'b0, hsize}) begin
			status_d = STATUS_SHORT;
		end else if (idx_inc == {1'b0, hsize}) begin
			status_d = STATUS_HDR_ONLY;
		end else begin
			status_d = STATUS_PAYLOAD;
		end

		pbyte_d = (status_d == STATUS_PAYLOAD) ? data_byte : 8'h00;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_index_q   <= '0;
			hdr_first_q    <= '0;
			hdr_second_q   <= '0;
			cur_seq_q      <= '0;
			cur_ts_q       <= '0;
			prev_seq_q     <= '0;
			seen_first_q   <= 1'b0;
			seq_err_q      <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				byte_index_q   <= byte_index_d;
				hdr_first_q    <= hdr_first_d;
				hdr_second_q   <= hdr_second_d;
				cur_seq_q      <= cur_seq_d;
				cur_ts_q       <= cur_ts_d;
				prev_seq_q     <= prev_seq_d;
				seen_first_q   <= seen_first_d;
				seq_err_q      <= seq_err_d;
				result_valid_q <= emit;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit) begin
			payload_byte_q <= pbyte_d;
			payload_last_q <= last_byte;
			status_q       <= status_d;
			seq_error_q    <= seq_err_d;
			out_first_q    <= hdr_first_d;
			out_second_q   <= hdr_second_d;
			out_seq_q      <= cur_seq_d;
			out_ts_q       <= cur_ts_d;
		end
	end

	assign result_valid    = result_valid_q;
	assign payload_byte    = payload_byte_q;
	assign payload_last    = payload_last_q;
	assign status          = status_q;
	assign seq_error       = seq_error_q;
	assign marker          = out_second_q[7];
	assign payload_type    = out_second_q[6:0];
	assign sequence_number = out_seq_q;
	assign timestamp       = out_ts_q;
	assign csrc_count      = out_first_q[3:0];
	assign version         = out_first_q[7:6];
	assign padding_flag    = out_first_q[5];
	assign extension_flag  = out_first_q[4];

	`RHD_ASSERT_NOW(a_index_bound, 1'b1, byte_index_q <= HDR_MAX, "byte position past header")
	`RHD_ASSERT_NOW(a_status_last, result_valid && status != STATUS_PAYLOAD,
		payload_last && payload_byte == 8'h00, "status result not final or nonzero")
	`RHD_ASSERT_NEXT(a_last_rewinds, accept && last_byte, byte_index_q == '0,
		"final byte did not rewind position")
	`RHD_ASSERT_NEXT(a_seq_seen, accept && byte_index_q == IDX_SEQ_LO, seen_first_q,
		"sequence capture not recorded")

endmodule
